// File: sv/apev_pkg.sv
// ----------------------------------------------------------------------------
// apev_pkg
// Shared types and constants of the absolute-pointer event decoder: event
// codes, the command that passes from the front part to the back part, the
// result item and the configuration register set.
// ----------------------------------------------------------------------------
`default_nettype none

package apev_pkg;

  // Screen coordinate width.
  localparam int COORD_BITS = 12;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // Field widths.
  localparam int SIZE_W  = 13;
  localparam int RAW_W   = 32;
  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int BTN_W   = 3;
  localparam int PROD_W  = RAW_W + SIZE_W;
  localparam int DIVC_W  = $clog2(PROD_W);

  // Stream payload widths.
  localparam int IN_DATA_W  = TYPE_W + CODE_W + RAW_W;
  localparam int OUT_BITS   = 2 * COORD_BITS + 2 * BTN_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Command queue.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Event types and codes.
  localparam logic [TYPE_W-1:0] EV_SYN = 16'h0000;
  localparam logic [TYPE_W-1:0] EV_KEY = 16'h0001;
  localparam logic [TYPE_W-1:0] EV_ABS = 16'h0003;

  localparam logic [CODE_W-1:0] ABS_X   = 16'h0000;
  localparam logic [CODE_W-1:0] ABS_Y   = 16'h0001;
  localparam logic [CODE_W-1:0] KEY_LMB = 16'h0110;
  localparam logic [CODE_W-1:0] KEY_RMB = 16'h0111;
  localparam logic [CODE_W-1:0] KEY_MMB = 16'h0112;

  localparam logic [BTN_W-1:0] BIT_NONE   = 3'd0;
  localparam logic [BTN_W-1:0] BIT_LEFT   = 3'd1;
  localparam logic [BTN_W-1:0] BIT_RIGHT  = 3'd2;
  localparam logic [BTN_W-1:0] BIT_MIDDLE = 3'd4;

  localparam logic [RAW_W-1:0] KEY_DOWN = 32'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_W = 2'd0;
  localparam logic [1:0] REG_SCREEN_H = 2'd1;
  localparam logic [1:0] REG_AXIS_X   = 2'd2;
  localparam logic [1:0] REG_AXIS_Y   = 2'd3;

  localparam logic [SIZE_W-1:0] RST_SCREEN_W = 13'd1280;
  localparam logic [SIZE_W-1:0] RST_SCREEN_H = 13'd800;
  localparam logic [RAW_W-1:0]  RST_AXIS_MAX = 32'h0000_7FFF;

  typedef enum logic [2:0] {
    OP_SET_X,
    OP_SET_Y,
    OP_SYNC,
    OP_FLUSH,
    OP_KEY
  } op_e;

  typedef enum logic {
    ACT_MOVE,
    ACT_BUTTON
  } act_e;

  typedef struct packed {
    op_e              op;
    logic [BTN_W-1:0] btn;
    logic             down;
    logic [RAW_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] screen_w;
    logic [SIZE_W-1:0] screen_h;
    logic [RAW_W-1:0]  axis_x_max;
    logic [RAW_W-1:0]  axis_y_max;
  } cfg_t;

  typedef struct packed {
    act_e                  action;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [BTN_W-1:0]      button_bit;
    logic                  pressed;
    logic [BTN_W-1:0]      held_buttons;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

// File: sv/abs_pointer_event_decoder_top.sv
// ----------------------------------------------------------------------------
// abs_pointer_event_decoder_top
// Decodes absolute-pointer tablet events into pointer moves and button
// changes.
//
// Input stream: one item per device event (type, code, value) or, with tuser
// high, an end-of-batch marker. Absolute X and Y items only latch the raw
// position; a sync, key or end-of-batch item turns pending motion into a
// screen position by scaling raw * (size - 1) / axis maximum with a clamp.
// Output stream: up to two result items per input item, tlast on the final
// one; tuser tells a move from a button change.
// Timing: the front takes an item in every cycle while the two-entry command
// queue has room. Latches and syncs with nothing pending leave at one per cycle.
// Resolving motion runs the 45-step restoring divider (one per axis, both
// running together); a key or end-of-batch item then goes on to a move result
// and, when it carries a button change, to a button result as well.
// If the receiver stalls, the output register holds its item, the back part
// waits and the queue fills, after which s_axis_tready falls.
// Reset clears all pointer state, empties the queue and loads the register
// defaults: 1280 by 800 pixels and an axis maximum of 32767 on both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module abs_pointer_event_decoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [apev_pkg::RAW_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ev_type [15:0], ev_code [31:16], ev_value [63:32]
  input  logic [apev_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pos_x, pos_y, button_bit, pressed, held_buttons, zero fill
  output logic [apev_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // action [0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import apev_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    q_full, q_push, q_pop, q_empty;
  cmd_t    q_wcmd, q_rcmd;
  result_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_W: cfg_d.screen_w   = cfg_wdata_i[SIZE_W-1:0];
        REG_SCREEN_H: cfg_d.screen_h   = cfg_wdata_i[SIZE_W-1:0];
        REG_AXIS_X:   cfg_d.axis_x_max = cfg_wdata_i;
        REG_AXIS_Y:   cfg_d.axis_y_max = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w   <= RST_SCREEN_W;
      cfg_q.screen_h   <= RST_SCREEN_H;
      cfg_q.axis_x_max <= RST_AXIS_MAX;
      cfg_q.axis_y_max <= RST_AXIS_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  apev_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .ev_type_i  (s_axis_tdata[TYPE_W-1:0]),
    .ev_code_i  (s_axis_tdata[TYPE_W+CODE_W-1:TYPE_W]),
    .ev_value_i (s_axis_tdata[IN_DATA_W-1:TYPE_W+CODE_W]),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wcmd)
  );

  apev_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rcmd),
    .empty_o (q_empty)
  );

  apev_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = OUT_DATA_W'({res.held_buttons, res.pressed, res.button_bit,
                                     res.pos_y, res.pos_x});
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// File: sv/apev_front.sv
// ----------------------------------------------------------------------------
// apev_front
// Input side: takes device events and end-of-batch items, sorts them into
// commands and drops the ones that can have no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module apev_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [apev_pkg::TYPE_W-1:0]   ev_type_i,
  input  logic [apev_pkg::CODE_W-1:0]   ev_code_i,
  input  logic [apev_pkg::RAW_W-1:0]    ev_value_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output apev_pkg::cmd_t                q_cmd_o
);
  import apev_pkg::*;

  logic keep;

  always_comb begin
    keep           = 1'b0;
    q_cmd_o.op     = OP_SYNC;
    q_cmd_o.btn    = BIT_NONE;
    q_cmd_o.down   = (ev_value_i == KEY_DOWN);
    q_cmd_o.value  = ev_value_i;
    if (kind_i) begin
      keep       = 1'b1;
      q_cmd_o.op = OP_FLUSH;
    end else begin
      case (ev_type_i)
        EV_SYN: begin
          keep       = 1'b1;
          q_cmd_o.op = OP_SYNC;
        end
        EV_ABS: begin
          if (ev_code_i == ABS_X) begin
            keep       = 1'b1;
            q_cmd_o.op = OP_SET_X;
          end else if (ev_code_i == ABS_Y) begin
            keep       = 1'b1;
            q_cmd_o.op = OP_SET_Y;
          end
        end
        EV_KEY: begin
          // Any key resolves motion; only the three buttons touch the mask.
          keep       = 1'b1;
          q_cmd_o.op = OP_KEY;
          case (ev_code_i)
            KEY_LMB: q_cmd_o.btn = BIT_LEFT;
            KEY_RMB: q_cmd_o.btn = BIT_RIGHT;
            KEY_MMB: q_cmd_o.btn = BIT_MIDDLE;
            default: q_cmd_o.btn = BIT_NONE;
          endcase
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

// File: sv/apev_fifo.sv
// ----------------------------------------------------------------------------
// apev_fifo
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module apev_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  apev_pkg::cmd_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output apev_pkg::cmd_t  rdata_o,
  output logic            empty_o
);
  import apev_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/apev_scale.sv
// ----------------------------------------------------------------------------
// apev_scale
// Scales one raw axis value to a screen coordinate: one multiply, then a
// restoring division one quotient bit per cycle, then the clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module apev_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [apev_pkg::RAW_W-1:0]      raw_i,
  input  logic [apev_pkg::SIZE_W-1:0]     size_i,
  input  logic [apev_pkg::RAW_W-1:0]      amax_i,
  output logic                            busy_o,
  output logic [apev_pkg::COORD_BITS-1:0] coord_o
);
  import apev_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam int CMP_W = SIZE_W + COORD_BITS;

  logic [1:0]            state_q, state_d;
  logic [DIVC_W-1:0]     cnt_q, cnt_d;
  logic [RAW_W-1:0]      raw_q, raw_d;
  logic [SIZE_W-1:0]     size_m1_q, size_m1_d;
  logic [RAW_W-1:0]      amax_q, amax_d;
  logic                  zero_q, zero_d;
  logic [COORD_BITS-1:0] lim_q, lim_d;
  logic [PROD_W-1:0]     dvd_q, dvd_d;
  logic [RAW_W-1:0]      rem_q, rem_d;
  logic [COORD_BITS-1:0] quo_q, quo_d;
  logic                  ovf_q, ovf_d;
  logic [COORD_BITS-1:0] coord_q, coord_d;
  logic [RAW_W:0]        trial;
  logic [RAW_W:0]        diff;
  logic                  ge;

  assign trial = {rem_q, dvd_q[PROD_W-1]};
  assign diff  = trial - {1'b0, amax_q};
  assign ge    = (trial >= {1'b0, amax_q});

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    raw_d     = raw_q;
    size_m1_d = size_m1_q;
    amax_d    = amax_q;
    zero_d    = zero_q;
    lim_d     = lim_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    ovf_d     = ovf_q;
    coord_d   = coord_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          raw_d     = raw_i;
          size_m1_d = size_i - 1'b1;
          amax_d    = amax_i;
          zero_d    = (size_i == '0) || (amax_i == '0);
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        dvd_d = PROD_W'(raw_q) * PROD_W'(size_m1_q);
        if (CMP_W'(size_m1_q) > CMP_W'(COORD_MAX)) begin
          lim_d = COORD_MAX;
        end else begin
          lim_d = COORD_BITS'(size_m1_q);
        end
        rem_d   = '0;
        quo_d   = '0;
        ovf_d   = 1'b0;
        cnt_d   = DIVC_W'(PROD_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
        dvd_d = {dvd_q[PROD_W-2:0], 1'b0};
        // A quotient bit that leaves the top means the result is past any limit.
        ovf_d = ovf_q | quo_q[COORD_BITS-1];
        quo_d = {quo_q[COORD_BITS-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (zero_q) begin
          coord_d = '0;
        end else if (ovf_q || (quo_q > lim_q)) begin
          coord_d = lim_q;
        end else begin
          coord_d = quo_q;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    raw_q     <= raw_d;
    size_m1_q <= size_m1_d;
    amax_q    <= amax_d;
    zero_q    <= zero_d;
    lim_q     <= lim_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    ovf_q     <= ovf_d;
    coord_q   <= coord_d;
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign coord_o = coord_q;

endmodule

`default_nettype wire

// File: sv/apev_back.sv
// ----------------------------------------------------------------------------
// apev_back
// Executes queued commands: holds the pointer state, runs the two axis
// scalers and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module apev_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apev_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  input  apev_pkg::cmd_t    q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output apev_pkg::result_t out_o
);
  import apev_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_MOVE  = 2'd2;
  localparam logic [1:0] ST_BTN   = 2'd3;

  logic [1:0]            state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [RAW_W-1:0]      raw_x_q, raw_x_d;
  logic [RAW_W-1:0]      raw_y_q, raw_y_d;
  logic                  pending_q, pending_d;
  logic                  svalid_q, svalid_d;
  logic [COORD_BITS-1:0] sx_q, sx_d;
  logic [COORD_BITS-1:0] sy_q, sy_d;
  logic [BTN_W-1:0]      mask_q, mask_d;
  logic                  ovalid_q, ovalid_d;
  result_t               out_q, out_d;
  logic                  start;
  logic                  x_busy, y_busy;
  logic [COORD_BITS-1:0] x_coord, y_coord;
  logic                  out_free;
  logic                  has_btn;
  logic [BTN_W-1:0]      new_mask;

  apev_scale u_scale_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .raw_i   (raw_x_q),
    .size_i  (cfg_i.screen_w),
    .amax_i  (cfg_i.axis_x_max),
    .busy_o  (x_busy),
    .coord_o (x_coord)
  );

  apev_scale u_scale_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .raw_i   (raw_y_q),
    .size_i  (cfg_i.screen_h),
    .amax_i  (cfg_i.axis_y_max),
    .busy_o  (y_busy),
    .coord_o (y_coord)
  );

  assign out_free = !ovalid_q || out_ready_i;
  assign has_btn  = (cmd_q.op == OP_KEY) && (cmd_q.btn != BIT_NONE);
  assign new_mask = cmd_q.down ? (mask_q | cmd_q.btn) : (mask_q & ~cmd_q.btn);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    raw_x_d   = raw_x_q;
    raw_y_d   = raw_y_q;
    pending_d = pending_q;
    svalid_d  = svalid_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    mask_d    = mask_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    out_d     = out_q;
    start     = 1'b0;
    q_pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          case (q_cmd_i.op)
            OP_SET_X: begin
              raw_x_d   = q_cmd_i.value;
              pending_d = 1'b1;
            end
            OP_SET_Y: begin
              raw_y_d   = q_cmd_i.value;
              pending_d = 1'b1;
            end
            default: begin
              if (pending_q) begin
                start   = 1'b1;
                state_d = ST_SCALE;
              end else if (q_cmd_i.op != OP_SYNC) begin
                state_d = ST_MOVE;
              end
            end
          endcase
        end
      end
      ST_SCALE: begin
        if (!x_busy && !y_busy) begin
          sx_d      = x_coord;
          sy_d      = y_coord;
          svalid_d  = 1'b1;
          pending_d = 1'b0;
          state_d   = (cmd_q.op == OP_SYNC) ? ST_IDLE : ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (!svalid_q) begin
          state_d = has_btn ? ST_BTN : ST_IDLE;
        end else if (out_free) begin
          ovalid_d           = 1'b1;
          out_d.action       = ACT_MOVE;
          out_d.pos_x        = sx_q;
          out_d.pos_y        = sy_q;
          out_d.button_bit   = BIT_NONE;
          out_d.pressed      = 1'b0;
          out_d.held_buttons = mask_q;
          out_d.last         = !has_btn;
          state_d            = has_btn ? ST_BTN : ST_IDLE;
        end
      end
      ST_BTN: begin
        if (out_free) begin
          mask_d             = new_mask;
          ovalid_d           = 1'b1;
          out_d.action       = ACT_BUTTON;
          out_d.pos_x        = sx_q;
          out_d.pos_y        = sy_q;
          out_d.button_bit   = cmd_q.btn;
          out_d.pressed      = cmd_q.down;
          out_d.held_buttons = new_mask;
          out_d.last         = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      raw_x_q   <= '0;
      raw_y_q   <= '0;
      pending_q <= 1'b0;
      svalid_q  <= 1'b0;
      sx_q      <= '0;
      sy_q      <= '0;
      mask_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      raw_x_q   <= raw_x_d;
      raw_y_q   <= raw_y_d;
      pending_q <= pending_d;
      svalid_q  <= svalid_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      mask_q    <= mask_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
